@@ hw/rtl/vsc_pkg.sv @@
// ----------------------------------------------------------------------------
// vsc_pkg
// Shared types, constants and character class helpers for the version
// string comparator.
// ----------------------------------------------------------------------------
`default_nettype none

package vsc_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;

    localparam logic signed [1:0] ORDER_GT = 2'sb01;
    localparam logic signed [1:0] ORDER_EQ = 2'sb00;
    localparam logic signed [1:0] ORDER_LT = 2'sb11;

    typedef struct packed {
        logic [7:0] a_char;
        logic [7:0] b_char;
        logic       last;
    } item_t;

    typedef struct packed {
        logic signed [1:0] order;
        logic              too_long;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= CHAR_LA) && (c <= CHAR_LZ)) || ((c >= CHAR_UA) && (c <= CHAR_UZ));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = is_digit(c) || is_alpha(c);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/version_string_compare_top.sv @@
// ----------------------------------------------------------------------------
// version_string_compare_top
// Loads two version strings one byte position per transaction, then walks
// both buffers segment by segment and returns a three-way order.
//
//   channel  dir  handshake                      payload
//   item     in   item_valid / item_stall        a_char, b_char, last
//   result   out  result_valid / result_stall    order, too_long
//
// loading accepts one position per cycle; after last, item_stall stays high
// through the walk and the result stage; each pointer step has a read phase
// and a decision phase (one registered read port per buffer)
// an overflowed pair skips the walk and goes straight to the result stage
// reset clears the sequencer and load counters; buffers are not cleared
// a pending result may wait under result_stall while the next pair loads
// ----------------------------------------------------------------------------
`default_nettype none

module version_string_compare_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire vsc_pkg::item_t  item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output vsc_pkg::result_t     result
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_SKIP = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_ZERO = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    localparam logic [vsc_pkg::CNT_W-1:0] LEN_MAX = vsc_pkg::CNT_W'(vsc_pkg::MAX_LEN);
    localparam logic [vsc_pkg::CNT_W-1:0] ONE     = vsc_pkg::CNT_W'(1);

    logic [7:0] mem_a [vsc_pkg::MAX_LEN];
    logic [7:0] mem_b [vsc_pkg::MAX_LEN];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;

    logic [2:0]                state_reg, state_next;
    logic                      phase_reg, phase_next;
    logic [vsc_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [vsc_pkg::CNT_W-1:0] a_len_reg, a_len_next;
    logic [vsc_pkg::CNT_W-1:0] b_len_reg, b_len_next;
    logic                      a_done_reg, a_done_next;
    logic                      b_done_reg, b_done_next;
    logic                      ovf_reg, ovf_next;
    logic [vsc_pkg::CNT_W-1:0] la_reg, la_next;
    logic [vsc_pkg::CNT_W-1:0] lb_reg, lb_next;
    logic [vsc_pkg::CNT_W-1:0] i_reg, i_next;
    logic [vsc_pkg::CNT_W-1:0] j_reg, j_next;
    logic [vsc_pkg::CNT_W-1:0] si_reg, si_next;
    logic [vsc_pkg::CNT_W-1:0] sj_reg, sj_next;
    logic                      numeric_reg, numeric_next;
    logic signed [1:0]         order_reg, order_next;
    logic                      long_reg, long_next;
    logic                      res_valid_reg, res_valid_next;
    vsc_pkg::result_t          res_data_reg, res_data_next;

    logic                      item_acc;
    logic                      pos_full;
    logic                      res_free;
    logic [vsc_pkg::ADDR_W-1:0] addr_a;
    logic [vsc_pkg::ADDR_W-1:0] addr_b;
    logic [vsc_pkg::CNT_W-1:0] a_len_upd;
    logic [vsc_pkg::CNT_W-1:0] b_len_upd;
    logic                      ovf_upd;
    logic                      a_in, b_in;
    logic                      a_sep, b_sep;
    logic [7:0]                ca, cb;
    logic                      a_more, b_more;
    logic                      a_z, b_z;
    logic [vsc_pkg::CNT_W-1:0] seg_a, seg_b;

    assign item_stall   = (state_reg != S_LOAD);
    assign item_acc     = item_valid && !item_stall;
    assign pos_full     = (pos_reg == LEN_MAX);
    assign res_free     = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign result       = res_data_reg;

    assign addr_a = (state_reg == S_SCAN) ? si_reg[vsc_pkg::ADDR_W-1:0]
                                          : i_reg[vsc_pkg::ADDR_W-1:0];
    assign addr_b = (state_reg == S_SCAN) ? sj_reg[vsc_pkg::ADDR_W-1:0]
                                          : j_reg[vsc_pkg::ADDR_W-1:0];

    // buffers: one write port for loading, one registered read port each
    always_ff @(posedge clk)
    begin
        if (item_acc && !pos_full)
        begin
            mem_a[pos_reg[vsc_pkg::ADDR_W-1:0]] <= item.a_char;
            mem_b[pos_reg[vsc_pkg::ADDR_W-1:0]] <= item.b_char;
        end
        rd_a_reg <= mem_a[addr_a];
        rd_b_reg <= mem_b[addr_b];
    end

    always_comb
    begin
        a_len_upd = a_len_reg;
        b_len_upd = b_len_reg;
        if (!pos_full && !a_done_reg && (item.a_char != 8'd0))
        begin
            a_len_upd = a_len_reg + ONE;
        end
        if (!pos_full && !b_done_reg && (item.b_char != 8'd0))
        begin
            b_len_upd = b_len_reg + ONE;
        end
        ovf_upd = ovf_reg || (pos_full && ((item.a_char != 8'd0) || (item.b_char != 8'd0)));

        a_in   = (i_reg < la_reg);
        b_in   = (j_reg < lb_reg);
        a_sep  = a_in && !vsc_pkg::is_alnum(rd_a_reg) && (rd_a_reg != vsc_pkg::CHAR_TILDE);
        b_sep  = b_in && !vsc_pkg::is_alnum(rd_b_reg) && (rd_b_reg != vsc_pkg::CHAR_TILDE);
        ca     = a_in ? rd_a_reg : 8'd0;
        cb     = b_in ? rd_b_reg : 8'd0;
        a_more = (si_reg < la_reg) && (numeric_reg ? vsc_pkg::is_digit(rd_a_reg)
                                                   : vsc_pkg::is_alpha(rd_a_reg));
        b_more = (sj_reg < lb_reg) && (numeric_reg ? vsc_pkg::is_digit(rd_b_reg)
                                                   : vsc_pkg::is_alpha(rd_b_reg));
        a_z    = (i_reg < si_reg) && (rd_a_reg == vsc_pkg::CHAR_ZERO);
        b_z    = (j_reg < sj_reg) && (rd_b_reg == vsc_pkg::CHAR_ZERO);
        seg_a  = si_reg - i_reg;
        seg_b  = sj_reg - j_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        a_len_next     = a_len_reg;
        b_len_next     = b_len_reg;
        a_done_next    = a_done_reg;
        b_done_next    = b_done_reg;
        ovf_next       = ovf_reg;
        la_next        = la_reg;
        lb_next        = lb_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        numeric_next   = numeric_reg;
        order_next     = order_reg;
        long_next      = long_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_data_next  = res_data_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (item_acc)
                begin
                    a_len_next = a_len_upd;
                    b_len_next = b_len_upd;
                    ovf_next   = ovf_upd;
                    if (!pos_full)
                    begin
                        pos_next = pos_reg + ONE;
                        if (item.a_char == 8'd0)
                        begin
                            a_done_next = 1'b1;
                        end
                        if (item.b_char == 8'd0)
                        begin
                            b_done_next = 1'b1;
                        end
                    end
                    if (item.last)
                    begin
                        la_next     = a_len_upd;
                        lb_next     = b_len_upd;
                        long_next   = ovf_upd;
                        order_next  = vsc_pkg::ORDER_EQ;
                        i_next      = '0;
                        j_next      = '0;
                        si_next     = '0;
                        sj_next     = '0;
                        phase_next  = 1'b0;
                        pos_next    = '0;
                        a_len_next  = '0;
                        b_len_next  = '0;
                        a_done_next = 1'b0;
                        b_done_next = 1'b0;
                        ovf_next    = 1'b0;
                        state_next  = ovf_upd ? S_RES : S_SKIP;
                    end
                end
            end

            S_SKIP:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (a_sep || b_sep)
                    begin
                        if (a_sep)
                        begin
                            i_next = i_reg + ONE;
                        end
                        if (b_sep)
                        begin
                            j_next = j_reg + ONE;
                        end
                    end
                    else if ((ca == vsc_pkg::CHAR_TILDE) || (cb == vsc_pkg::CHAR_TILDE))
                    begin
                        if (ca != vsc_pkg::CHAR_TILDE)
                        begin
                            order_next = vsc_pkg::ORDER_GT;
                            state_next = S_RES;
                        end
                        else if (cb != vsc_pkg::CHAR_TILDE)
                        begin
                            order_next = vsc_pkg::ORDER_LT;
                            state_next = S_RES;
                        end
                        else
                        begin
                            i_next = i_reg + ONE;
                            j_next = j_reg + ONE;
                        end
                    end
                    else if (!a_in || !b_in)
                    begin
                        if (!a_in && !b_in)
                        begin
                            order_next = vsc_pkg::ORDER_EQ;
                        end
                        else if (!a_in)
                        begin
                            order_next = vsc_pkg::ORDER_LT;
                        end
                        else
                        begin
                            order_next = vsc_pkg::ORDER_GT;
                        end
                        state_next = S_RES;
                    end
                    else
                    begin
                        numeric_next = vsc_pkg::is_digit(ca);
                        si_next      = i_reg;
                        sj_next      = j_reg;
                        state_next   = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (a_more || b_more)
                    begin
                        if (a_more)
                        begin
                            si_next = si_reg + ONE;
                        end
                        if (b_more)
                        begin
                            sj_next = sj_reg + ONE;
                        end
                    end
                    else if (sj_reg == j_reg)
                    begin
                        order_next = numeric_reg ? vsc_pkg::ORDER_LT : vsc_pkg::ORDER_GT;
                        state_next = S_RES;
                    end
                    else
                    begin
                        state_next = numeric_reg ? S_ZERO : S_CMP;
                    end
                end
            end

            S_ZERO:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (a_z || b_z)
                    begin
                        if (a_z)
                        begin
                            i_next = i_reg + ONE;
                        end
                        if (b_z)
                        begin
                            j_next = j_reg + ONE;
                        end
                    end
                    else if (seg_a > seg_b)
                    begin
                        order_next = vsc_pkg::ORDER_GT;
                        state_next = S_RES;
                    end
                    else if (seg_b > seg_a)
                    begin
                        order_next = vsc_pkg::ORDER_LT;
                        state_next = S_RES;
                    end
                    else
                    begin
                        state_next = S_CMP;
                    end
                end
            end

            S_CMP:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if ((i_reg < si_reg) && (j_reg < sj_reg))
                    begin
                        if (rd_a_reg != rd_b_reg)
                        begin
                            order_next = (rd_a_reg > rd_b_reg) ? vsc_pkg::ORDER_GT
                                                               : vsc_pkg::ORDER_LT;
                            state_next = S_RES;
                        end
                        else
                        begin
                            i_next = i_reg + ONE;
                            j_next = j_reg + ONE;
                        end
                    end
                    else if (i_reg < si_reg)
                    begin
                        order_next = vsc_pkg::ORDER_GT;
                        state_next = S_RES;
                    end
                    else if (j_reg < sj_reg)
                    begin
                        order_next = vsc_pkg::ORDER_LT;
                        state_next = S_RES;
                    end
                    else
                    begin
                        i_next     = si_reg;
                        j_next     = sj_reg;
                        state_next = S_SKIP;
                    end
                end
            end

            S_RES:
            begin
                phase_next = 1'b0;
                if (res_free)
                begin
                    res_valid_next         = 1'b1;
                    res_data_next.order    = long_reg ? vsc_pkg::ORDER_EQ : order_reg;
                    res_data_next.too_long = long_reg;
                    state_next             = S_LOAD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
                phase_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            phase_reg     <= 1'b0;
            pos_reg       <= '0;
            a_len_reg     <= '0;
            b_len_reg     <= '0;
            a_done_reg    <= 1'b0;
            b_done_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            la_reg        <= '0;
            lb_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            si_reg        <= '0;
            sj_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            a_len_reg     <= a_len_next;
            b_len_reg     <= b_len_next;
            a_done_reg    <= a_done_next;
            b_done_reg    <= b_done_next;
            ovf_reg       <= ovf_next;
            la_reg        <= la_next;
            lb_reg        <= lb_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            si_reg        <= si_next;
            sj_reg        <= sj_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        numeric_reg  <= numeric_next;
        order_reg    <= order_next;
        long_reg     <= long_next;
        res_data_reg <= res_data_next;
    end

    // a last transaction always hands control to the walk or the result stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && item.last) |=> item_stall)
        else $error("last transaction did not start a comparison");

    // walk pointers never pass the string lengths
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> ((i_reg <= la_reg) && (j_reg <= lb_reg)
                                   && (si_reg <= la_reg) && (sj_reg <= lb_reg)))
        else $error("walk pointer beyond string length");

    // pointers hold during the read cycle of a step
    assert property (@(posedge clk) disable iff (!rst_n)
        (!phase_reg && ((state_reg == S_SKIP) || (state_reg == S_SCAN)
                        || (state_reg == S_ZERO) || (state_reg == S_CMP)))
        |=> ($stable(i_reg) && $stable(j_reg) && $stable(si_reg) && $stable(sj_reg)))
        else $error("pointer moved before read data was ready");

    // an overflowed pair reports equal order
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.too_long) |-> (result.order == vsc_pkg::ORDER_EQ))
        else $error("overflow result with nonzero order");

    // the load position saturates at the buffer depth and bounds both string lengths
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg <= LEN_MAX) && (a_len_reg <= pos_reg) && (b_len_reg <= pos_reg))
        else $error("load counters out of range");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for version_string_compare_top. Streams pairs of
// version strings one byte position per transaction: first a few hand
// picked pairs, then random versions, near copies, noise, trailing junk and
// buffer overflows. Each accepted position updates a local model of the
// comparator; results are checked in order against the predicted order and
// too_long flags. The item channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int ITEM_TARGET    = 1900;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    vsc_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    vsc_pkg::result_t result;

    vsc_pkg::item_t    position_queue[$];
    vsc_pkg::result_t  awaited_orders[$];
    logic [7:0]        text_a[$];
    logic [7:0]        text_b[$];

    logic [7:0]  loaded [2][vsc_pkg::MAX_LEN];
    int          fill_pos   = 0;
    bit          overflowed = 1'b0;

    int          mismatches  = 0;
    int          cycle_no    = 0;
    int          gap_left    = 0;
    int          hold_left   = 0;
    int          idle_cycles = 0;

    version_string_compare_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
        cycle_no <= cycle_no + 1;

    // character classes
    function automatic bit is_num_byte(input logic [7:0] c);
        return (c >= vsc_pkg::CHAR_ZERO) && (c <= vsc_pkg::CHAR_NINE);
    endfunction

    function automatic bit is_letter_byte(input logic [7:0] c);
        return ((c >= vsc_pkg::CHAR_LA) && (c <= vsc_pkg::CHAR_LZ))
               || ((c >= vsc_pkg::CHAR_UA) && (c <= vsc_pkg::CHAR_UZ));
    endfunction

    function automatic bit is_gap_byte(input logic [7:0] c);
        return !is_num_byte(c) && !is_letter_byte(c) && (c != vsc_pkg::CHAR_TILDE);
    endfunction

    function automatic int text_len(input int side);
        int n;
        n = 0;
        while (n < fill_pos && n < vsc_pkg::MAX_LEN && loaded[side][n] != 8'h00)
            n++;
        return n;
    endfunction

    function automatic logic signed [1:0] rank_versions(input int la, input int lb);
        int         i;
        int         j;
        int         si;
        int         sj;
        logic [7:0] fa;
        logic [7:0] fb;
        bit         numeric;
        bit         same;
        i = 0;
        j = 0;
        if (la == lb)
        begin
            same = 1'b1;
            for (int k = 0; k < la; k++)
                if (loaded[0][k] != loaded[1][k])
                    same = 1'b0;
            if (same)
                return vsc_pkg::ORDER_EQ;
        end
        while (i < la || j < lb)
        begin
            while (i < la && is_gap_byte(loaded[0][i]))
                i++;
            while (j < lb && is_gap_byte(loaded[1][j]))
                j++;
            fa = (i < la) ? loaded[0][i] : 8'h00;
            fb = (j < lb) ? loaded[1][j] : 8'h00;
            // tilde sorts before everything, end of string included
            if (fa == vsc_pkg::CHAR_TILDE || fb == vsc_pkg::CHAR_TILDE)
            begin
                if (fa != vsc_pkg::CHAR_TILDE)
                    return vsc_pkg::ORDER_GT;
                if (fb != vsc_pkg::CHAR_TILDE)
                    return vsc_pkg::ORDER_LT;
                i++;
                j++;
                continue;
            end
            if (i >= la || j >= lb)
                break;
            si = i;
            sj = j;
            numeric = is_num_byte(loaded[0][i]);
            if (numeric)
            begin
                while (si < la && is_num_byte(loaded[0][si]))
                    si++;
                while (sj < lb && is_num_byte(loaded[1][sj]))
                    sj++;
            end
            else
            begin
                while (si < la && is_letter_byte(loaded[0][si]))
                    si++;
                while (sj < lb && is_letter_byte(loaded[1][sj]))
                    sj++;
            end
            if (sj == j)
                return numeric ? vsc_pkg::ORDER_LT : vsc_pkg::ORDER_GT;
            if (numeric)
            begin
                while (i < si && loaded[0][i] == vsc_pkg::CHAR_ZERO)
                    i++;
                while (j < sj && loaded[1][j] == vsc_pkg::CHAR_ZERO)
                    j++;
                if (si - i > sj - j)
                    return vsc_pkg::ORDER_GT;
                if (sj - j > si - i)
                    return vsc_pkg::ORDER_LT;
            end
            while (i < si && j < sj)
            begin
                if (loaded[0][i] != loaded[1][j])
                    return (loaded[0][i] > loaded[1][j]) ? vsc_pkg::ORDER_GT
                                                         : vsc_pkg::ORDER_LT;
                i++;
                j++;
            end
            if (i < si)
                return vsc_pkg::ORDER_GT;
            if (j < sj)
                return vsc_pkg::ORDER_LT;
            i = si;
            j = sj;
        end
        if (i >= la && j >= lb)
            return vsc_pkg::ORDER_EQ;
        return (i >= la) ? vsc_pkg::ORDER_LT : vsc_pkg::ORDER_GT;
    endfunction

    function automatic void absorb_position(input vsc_pkg::item_t it);
        vsc_pkg::result_t r;
        if (fill_pos < vsc_pkg::MAX_LEN)
        begin
            loaded[0][fill_pos] = it.a_char;
            loaded[1][fill_pos] = it.b_char;
            fill_pos++;
        end
        else if (it.a_char != 8'h00 || it.b_char != 8'h00)
            overflowed = 1'b1;
        if (it.last)
        begin
            r.too_long = overflowed;
            r.order    = overflowed ? vsc_pkg::ORDER_EQ
                                    : rank_versions(text_len(0), text_len(1));
            awaited_orders.push_back(r);
            fill_pos   = 0;
            overflowed = 1'b0;
        end
    endfunction

    // stimulus helpers
    function automatic logic [7:0] sep_char();
        case ($urandom_range(0, 4))
            0:       return 8'h2e;
            1:       return 8'h2d;
            2:       return 8'h5f;
            3:       return 8'h2b;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic logic [7:0] any_version_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return vsc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
            3, 4:    return vsc_pkg::CHAR_LA + 8'($urandom_range(0, 25));
            5:       return vsc_pkg::CHAR_UA + 8'($urandom_range(0, 25));
            6:       return vsc_pkg::CHAR_TILDE;
            7, 8:    return sep_char();
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic put(input int side, input logic [7:0] c);
        if (side == 0)
            text_a.push_back(c);
        else
            text_b.push_back(c);
    endtask

    task automatic load_texts(input string a, input string b);
        text_a.delete();
        text_b.delete();
        for (int k = 0; k < a.len(); k++)
            text_a.push_back(a[k]);
        for (int k = 0; k < b.len(); k++)
            text_b.push_back(b[k]);
    endtask

    task automatic fill_run(input int side, input int count);
        for (int k = 0; k < count; k++)
            put(side, any_version_char());
    endtask

    task automatic append_segment(input int side);
        int n;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                for (int k = 0; k < n; k++)
                    put(side, vsc_pkg::CHAR_ZERO);
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    put(side, vsc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            2, 3:
            begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    put(side, ($urandom_range(0, 3) == 0 ? vsc_pkg::CHAR_UA
                                                          : vsc_pkg::CHAR_LA)
                              + 8'($urandom_range(0, 3)));
            end
            4:       put(side, vsc_pkg::CHAR_TILDE);
            default: put(side, sep_char());
        endcase
    endtask

    task automatic make_version(input int side);
        int segments;
        segments = $urandom_range(0, 5);
        for (int s = 0; s < segments; s++)
        begin
            if (s > 0 && $urandom_range(0, 2) != 0)
                put(side, sep_char());
            append_segment(side);
        end
    endtask

    task automatic mutate_second();
        int pos;
        pos = (text_b.size() == 0) ? 0 : $urandom_range(0, text_b.size() - 1);
        case ($urandom_range(0, 5))
            0:
                if (text_b.size() != 0)
                    text_b[pos] = any_version_char();
            1: append_segment(1);
            2:
                if (text_b.size() != 0)
                    text_b.delete(text_b.size() - 1);
            3: text_b.insert(pos, vsc_pkg::CHAR_TILDE);
            4: text_b.insert(pos, vsc_pkg::CHAR_ZERO);
            default: ;
        endcase
    endtask

    task automatic send_pair(input int pad);
        int             n;
        vsc_pkg::item_t it;
        n = (text_a.size() > text_b.size()) ? text_a.size() : text_b.size();
        n = n + pad;
        if (n == 0)
            n = 1;
        for (int k = 0; k < n; k++)
        begin
            it.a_char = (k < text_a.size()) ? text_a[k] : 8'h00;
            it.b_char = (k < text_b.size()) ? text_b[k] : 8'h00;
            it.last   = (k == n - 1);
            position_queue.push_back(it);
        end
    endtask

    task automatic random_pair();
        int         kind;
        logic [7:0] swap_q[$];
        text_a.delete();
        text_b.delete();
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            make_version(0);
            if ($urandom_range(0, 2) == 0)
                make_version(1);
            else
            begin
                text_b = text_a;
                mutate_second();
            end
        end
        else if (kind < 80)
        begin
            repeat ($urandom_range(0, 10))
                text_a.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 10))
                text_b.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 88)
        begin
            fill_run(0, $urandom_range(58, 68));
            if ($urandom_range(0, 1) == 0)
                fill_run(1, $urandom_range(0, 68));
            else
            begin
                text_b = text_a;
                mutate_second();
            end
        end
        else
        begin
            make_version(0);
            make_version(1);
            text_a.push_back(8'h00);
            fill_run(0, $urandom_range(1, 4));
            if ($urandom_range(0, 1) == 0)
            begin
                text_b.push_back(8'h00);
                fill_run(1, $urandom_range(1, 4));
            end
        end
        if ($urandom_range(0, 1) == 0)
        begin
            swap_q = text_a;
            text_a = text_b;
            text_b = swap_q;
        end
        send_pair(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
    endtask

    // item channel driver
    always @(posedge clk or negedge rst_n)
    begin : position_driver
        int pause;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            gap_left   <= 0;
        end
        else if (item_valid && !item_stall)
        begin
            absorb_position(item);
            pause = cycle_no[8] ? 0 : $urandom_range(0, 11);
            if (pause == 0 && position_queue.size() != 0)
                item <= position_queue.pop_front();
            else
            begin
                item_valid <= 1'b0;
                gap_left   <= pause;
            end
        end
        else if (!item_valid)
        begin
            if (gap_left != 0)
                gap_left <= gap_left - 1;
            else if (position_queue.size() != 0)
            begin
                item       <= position_queue.pop_front();
                item_valid <= 1'b1;
            end
        end
    end

    // result channel monitor
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        vsc_pkg::result_t want;
        int               hold;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
        end
        else if (result_valid && !result_stall)
        begin
            if (awaited_orders.size() == 0)
            begin
                $error("unexpected transaction: order %0d, too_long %0b",
                       result.order, result.too_long);
                mismatches++;
            end
            else
            begin
                want = awaited_orders.pop_front();
                if (result.order !== want.order)
                begin
                    $error("order mismatch: expected %0d, got %0d", want.order, result.order);
                    mismatches++;
                end
                if (result.too_long !== want.too_long)
                begin
                    $error("too_long mismatch: expected %0b, got %0b",
                           want.too_long, result.too_long);
                    mismatches++;
                end
            end
            hold = cycle_no[9] ? 0 : $urandom_range(0, 11);
            hold_left    <= hold;
            result_stall <= (hold != 0);
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= (hold_left != 1);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        // directed pairs
        load_texts("1.0", "1.0");      send_pair(0);
        load_texts("1.10", "1.9");     send_pair(1);
        load_texts("1.0~rc1", "1.0");  send_pair(0);
        load_texts("~", "");           send_pair(0);
        load_texts("~~", "~");         send_pair(0);
        load_texts("a", "1");          send_pair(0);
        load_texts("1", "a");          send_pair(0);
        load_texts("007", "7");        send_pair(0);
        load_texts("1.0a", "1.0");     send_pair(0);
        load_texts("abc", "abd");      send_pair(0);
        load_texts("1_2", "1.2");      send_pair(0);
        load_texts("Z", "a");          send_pair(0);
        load_texts("1.0", "1.0.0");    send_pair(0);
        load_texts("", "");            send_pair(0);
        // high bytes act as separators
        load_texts("1", "1.2");
        text_a.push_back(8'hff);
        text_a.push_back(8'h80);
        text_a.push_back(8'h32);
        send_pair(0);
        // junk after the terminating zero
        load_texts("1.2", "1.2");
        text_a.push_back(8'h00);
        text_a.push_back(8'hff);
        send_pair(0);
        // both strings fill the buffer exactly
        load_texts("", "");
        fill_run(0, vsc_pkg::MAX_LEN);
        fill_run(1, vsc_pkg::MAX_LEN);
        send_pair(0);
        // first string one byte too long
        load_texts("", "1");
        fill_run(0, vsc_pkg::MAX_LEN + 1);
        send_pair(0);
        // second string too long
        load_texts("1", "");
        fill_run(1, vsc_pkg::MAX_LEN + 3);
        send_pair(0);
        // zero padding past the buffer end is not an overflow
        load_texts("2", "");
        fill_run(1, vsc_pkg::MAX_LEN);
        send_pair(2);

        while (position_queue.size() < ITEM_TARGET)
            random_pair();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (position_queue.size() != 0 || item_valid)
            @(posedge clk);
        while (awaited_orders.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/vsc_pkg.sv
hw/rtl/version_string_compare_top.sv
tb/tb.sv
